>>> hdl/dtmg_pkg.sv
package dtmg_pkg;

	// Notes per channel store and the width of a note index
	localparam int MAX_NOTES  = 32;
	localparam int NOTE_IDX_W = $clog2(MAX_NOTES);

	// Request command codes
	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_TONE_ON  = 3'd1,
		CMD_TONE_OFF = 3'd2,
		CMD_START    = 3'd3,
		CMD_STOP     = 3'd4,
		CMD_WRITE    = 3'd5
	} dtmg_cmd_t;

	// Per-channel strobes decoded from one accepted request
	typedef struct packed {
		logic tick;
		logic tone_on;
		logic tone_off;
		logic start;
		logic stop;
		logic write;
	} dtmg_ctl_t;

	// Per-channel status toward the result
	typedef struct packed {
		logic pin;
		logic playing;
		logic enabled;
	} dtmg_stat_t;

	// Note store entry: period high, duration low
	typedef struct packed {
		logic [15:0] period;
		logic [15:0] duration;
	} dtmg_note_t;

endpackage

>>> hdl/dual_tone_melody_generator.sv
// Latency: a request's result is presented the cycle after it is accepted.
// Throughput: one request per cycle while res_ready is high; the result register frees as it is taken,
// so a new request is accepted in the same cycle the previous result leaves.
// Reset (arst_n low, asynchronous): all counters, pins and flags clear;
// note stores are not cleared and read undefined until written.
module dual_tone_melody_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  command,
	input  logic        channel,
	input  logic [15:0] half_period,
	input  logic [5:0]  note_count,
	input  logic        repeat_req,
	input  logic [4:0]  note_index,
	input  logic [15:0] note_period,
	input  logic [15:0] note_duration,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        first_pin,
	output logic        second_pin,
	output logic        first_melody_playing,
	output logic        second_melody_playing,
	output logic        first_enabled,
	output logic        second_enabled
);
	import dtmg_pkg::*;

	logic                  accept;
	logic                  res_valid_q;
	dtmg_ctl_t             dec;
	dtmg_ctl_t             ctl0, ctl1;
	dtmg_stat_t            stat0, stat1;
	logic [NOTE_IDX_W-1:0] last_sel, write_idx;
	dtmg_note_t            write_note;

	assign req_ready = !res_valid_q || res_ready;
	assign accept    = req_valid && req_ready;
	assign res_valid = res_valid_q;

	// Result valid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Command decode
	always_comb begin
		dec = '0;
		unique case (dtmg_cmd_t'(command))
			CMD_TICK:     dec.tick     = stat0.enabled || stat1.enabled;
			CMD_TONE_ON:  dec.tone_on  = 1'b1;
			CMD_TONE_OFF: dec.tone_off = 1'b1;
			CMD_START:    dec.start    = 1'b1;
			CMD_STOP:     dec.stop     = 1'b1;
			CMD_WRITE:    dec.write    = int'(note_index) < MAX_NOTES;
			default:      dec = '0;
		endcase
	end

	// Steer to the addressed channel; ticks go to both
	always_comb begin
		ctl0      = '0;
		ctl1      = '0;
		ctl0.tick = accept && dec.tick;
		ctl1.tick = accept && dec.tick;
		if (accept && !channel) begin
			ctl0.tone_on  = dec.tone_on;
			ctl0.tone_off = dec.tone_off;
			ctl0.start    = dec.start;
			ctl0.stop     = dec.stop;
			ctl0.write    = dec.write;
		end
		if (accept && channel) begin
			ctl1.tone_on  = dec.tone_on;
			ctl1.tone_off = dec.tone_off;
			ctl1.start    = dec.start;
			ctl1.stop     = dec.stop;
			ctl1.write    = dec.write;
		end
	end

	// Last note index, count saturated to 1..MAX_NOTES
	always_comb begin
		if (note_count == '0)
			last_sel = '0;
		else if (int'(note_count) > MAX_NOTES)
			last_sel = NOTE_IDX_W'(MAX_NOTES - 1);
		else
			last_sel = NOTE_IDX_W'(note_count - 6'd1);
	end

	assign write_idx           = NOTE_IDX_W'(note_index);
	assign write_note.period   = note_period;
	assign write_note.duration = note_duration;

	dtmg_channel u_ch0 (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl0),
		.half_period(half_period),
		.last_sel   (last_sel),
		.repeat_req (repeat_req),
		.write_idx  (write_idx),
		.write_note (write_note),
		.stat       (stat0)
	);

	dtmg_channel u_ch1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl1),
		.half_period(half_period),
		.last_sel   (last_sel),
		.repeat_req (repeat_req),
		.write_idx  (write_idx),
		.write_note (write_note),
		.stat       (stat1)
	);

	assign first_pin             = stat0.pin;
	assign second_pin            = stat1.pin;
	assign first_melody_playing  = stat0.playing;
	assign second_melody_playing = stat1.playing;
	assign first_enabled         = stat0.enabled;
	assign second_enabled        = stat1.enabled;

endmodule

>>> hdl/dtmg_channel.sv
module dtmg_channel (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dtmg_pkg::dtmg_ctl_t                ctl,
	input  logic [15:0]                        half_period,
	input  logic [dtmg_pkg::NOTE_IDX_W-1:0]    last_sel,
	input  logic                               repeat_req,
	input  logic [dtmg_pkg::NOTE_IDX_W-1:0]    write_idx,
	input  dtmg_pkg::dtmg_note_t               write_note,
	output dtmg_pkg::dtmg_stat_t               stat
);
	import dtmg_pkg::*;

	// Control state
	logic [15:0]           tone_count_q, tone_border_q, dur_count_q;
	logic                  enabled_q, pin_q, active_q, repeat_q;
	logic [NOTE_IDX_W-1:0] cur_q, last_q;

	// Note store and cached entries: current duration, next note, note 0
	dtmg_note_t            notes_q [MAX_NOTES];
	logic [15:0]           cur_dur_q;
	dtmg_note_t            nxt_q;
	dtmg_note_t            note0_q;

	logic [15:0]           n_tone_count, n_tone_border, n_dur_count;
	logic                  n_enabled, n_pin, n_active, n_repeat;
	logic [NOTE_IDX_W-1:0] n_cur, n_last;
	logic [NOTE_IDX_W-1:0] nxt_idx, after_idx, rd_idx;
	logic [15:0]           tc_inc, dc_inc;
	logic                  advance;
	dtmg_note_t            rd_note;

	// Note after the current one, and the one after that
	assign nxt_idx   = (cur_q < last_q) ? cur_q + NOTE_IDX_W'(1) : '0;
	assign after_idx = (nxt_idx < last_q) ? nxt_idx + NOTE_IDX_W'(1) : '0;
	assign rd_idx    = ctl.start ? NOTE_IDX_W'(1) : after_idx;
	assign rd_note   = notes_q[rd_idx];

	assign tc_inc = tone_count_q + 16'd1;
	assign dc_inc = dur_count_q + 16'd1;

	// Next state for one request
	always_comb begin
		n_tone_count  = tone_count_q;
		n_tone_border = tone_border_q;
		n_dur_count   = dur_count_q;
		n_enabled     = enabled_q;
		n_pin         = pin_q;
		n_active      = active_q;
		n_repeat      = repeat_q;
		n_cur         = cur_q;
		n_last        = last_q;
		advance       = 1'b0;
		if (ctl.tick) begin
			n_tone_count = tc_inc;
			n_dur_count  = dc_inc;
			if (active_q && dc_inc >= cur_dur_q) begin
				advance       = 1'b1;
				n_dur_count   = '0;
				n_cur         = nxt_idx;
				n_tone_border = nxt_q.period;
				n_pin         = 1'b0;
				if (!repeat_q && nxt_idx == '0) begin
					n_active  = 1'b0;
					n_enabled = 1'b0;
				end
			end
			if (n_enabled && n_tone_count >= n_tone_border) begin
				n_tone_count = '0;
				n_pin        = ~n_pin;
			end
		end
		if (ctl.tone_on) begin
			n_enabled     = 1'b1;
			n_tone_border = half_period;
		end
		if (ctl.tone_off) begin
			n_enabled = 1'b0;
		end
		if (ctl.start) begin
			n_enabled     = 1'b1;
			n_active      = 1'b1;
			n_repeat      = repeat_req;
			n_cur         = '0;
			n_last        = last_sel;
			n_dur_count   = '0;
			n_tone_border = note0_q.period;
			n_pin         = 1'b0;
		end
		if (ctl.stop) begin
			n_active  = 1'b0;
			n_enabled = 1'b0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_count_q  <= '0;
			tone_border_q <= '0;
			dur_count_q   <= '0;
			enabled_q     <= 1'b0;
			pin_q         <= 1'b0;
			active_q      <= 1'b0;
			repeat_q      <= 1'b0;
			cur_q         <= '0;
			last_q        <= '0;
		end else begin
			tone_count_q  <= n_tone_count;
			tone_border_q <= n_tone_border;
			dur_count_q   <= n_dur_count;
			enabled_q     <= n_enabled;
			pin_q         <= n_pin;
			active_q      <= n_active;
			repeat_q      <= n_repeat;
			cur_q         <= n_cur;
			last_q        <= n_last;
		end
	end

	// Note store and caches; writes keep the caches coherent
	always_ff @(posedge clk) begin
		if (advance) begin
			cur_dur_q <= nxt_q.duration;
			nxt_q     <= rd_note;
		end
		if (ctl.start) begin
			cur_dur_q <= note0_q.duration;
			nxt_q     <= (last_sel == '0) ? note0_q : rd_note;
		end
		if (ctl.write) begin
			notes_q[write_idx] <= write_note;
			if (write_idx == cur_q)
				cur_dur_q <= write_note.duration;
			if (write_idx == nxt_idx)
				nxt_q <= write_note;
			if (write_idx == '0)
				note0_q <= write_note;
		end
	end

	assign stat.pin     = pin_q;
	assign stat.playing = active_q;
	assign stat.enabled = enabled_q;

`ifndef NO_ASSERTIONS
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> active_q && enabled_q && !pin_q && cur_q == '0)
		else $error("melody start did not set up the channel");
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.stop |=> !active_q && !enabled_q)
		else $error("melody stop left the channel running");
	a_note_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> cur_q <= last_q)
		else $error("current note beyond last note");
	a_note_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.tick && !ctl.start |=> $stable(cur_q))
		else $error("current note moved without tick or start");
`endif

endmodule
